>>> hw/rtl/cycle_peak_lookahead_gain_unit_macros.svh
// Assertion macros shared by the cycle peak lookahead gain unit.
`ifndef CYCLE_PEAK_LOOKAHEAD_GAIN_UNIT_MACROS_SVH
`define CYCLE_PEAK_LOOKAHEAD_GAIN_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define CPLG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define CPLG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/cplg_pkg.sv
// Types and constants of the cycle peak lookahead gain unit.
`default_nettype none
package cplg_pkg;
   localparam int GAIN_BITS     = 17;
   localparam int THR_BITS      = 24;
   localparam int RATIO_BITS    = 9;
   localparam int LEN_BITS      = 12;
   localparam int GUARD_BITS    = 16;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 24;

   localparam logic [GAIN_BITS-1:0]  UNITY_GAIN = 17'd65536;
   localparam logic [RATIO_BITS-1:0] RATIO_MIN  = 9'd16;
   localparam logic [RATIO_BITS-1:0] RATIO_MAX  = 9'd320;

   localparam logic [THR_BITS-1:0]   THRESHOLD_RESET = 24'd4194304;
   localparam logic [RATIO_BITS-1:0] RATIO_RESET     = 9'd64;
   localparam logic [LEN_BITS-1:0]   LOOKAHEAD_RESET = 12'd1440;
   localparam logic [GUARD_BITS-1:0] GUARD_RESET     = 16'd120;
   localparam logic [GUARD_BITS-1:0] COUNT_MAX       = 16'hFFFF;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] REG_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_RATIO     = 4'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_LOOKAHEAD = 4'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_GUARD     = 4'd3;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;
endpackage
`default_nettype wire

>>> hw/rtl/cplg_channels.sv
// Request, response and configuration channel interfaces.
`default_nettype none
interface cplg_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface cplg_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] delayed_sample;
   logic [16:0]                   gain;
   logic [SAMPLE_BITS-1:0]        live_cycle_peak;
   logic [SAMPLE_BITS-1:0]        delayed_cycle_peak;
   modport source (output valid, output delayed_sample, output gain,
                   output live_cycle_peak, output delayed_cycle_peak, input ready);
   modport sink   (input valid, input delayed_sample, input gain,
                   input live_cycle_peak, input delayed_cycle_peak, output ready);
endinterface

interface cplg_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [23:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cplg_ring_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module cplg_ring_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> hw/rtl/cplg_gain_div.sv
// Restoring divider, one quotient bit a cycle, with the quotient clamped to unity gain.
`default_nettype none
module cplg_gain_div #(
   parameter int NW = 51,
   parameter int DW = 33
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cplg_pkg::div_ctrl_type ctrl,
   input  wire logic [NW-1:0]         num,
   input  wire logic [DW-1:0]         den,
   output cplg_pkg::div_stat_type      stat,
   output logic [16:0]                gain
);
   import cplg_pkg::*;

   localparam int CW = $clog2(NW + 1);

   logic [DW:0]   rem_ff,  rem_in;
   logic [NW-1:0] num_ff,  num_in;
   logic [NW-1:0] quo_ff,  quo_in;
   logic [DW-1:0] den_ff,  den_in;
   logic [CW-1:0] cnt_ff,  cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;

   // One shift-and-subtract step.
   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DW-1:0], num_ff[NW-1]};
      if (ctrl.start) begin
         rem_in  = '0;
         num_in  = num;
         quo_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign gain = (quo_ff > NW'(UNITY_GAIN)) ? UNITY_GAIN : quo_ff[16:0];
endmodule
`default_nettype wire

>>> hw/rtl/cycle_peak_lookahead_gain_unit.sv
// Top level of the cycle peak lookahead gain unit.
`default_nettype none
`include "cycle_peak_lookahead_gain_unit_macros.svh"
// Lookahead peak compressor. Each request carries one signed sample; the unit tracks the
// full-wave peak of each input cycle, and at each rising zero crossing past the guard it
// computes a Q16 gain for the finished cycle and writes gain and peak back over the last
// min(cycle length, ring length) ring entries, the ring length being lookahead_len clamped
// to 1..DEPTH. Each request gives one response holding the sample, gain and peak from ring
// length minus one requests earlier, plus the peak of the last finished cycle. A request
// passes from acceptance through evaluation, the sample write, the RAM read and the output
// state, which waits while an untaken response still fills the response register. When a
// cycle ends, the write-back of the ring entries, one per cycle through the gain/peak RAM
// write port, comes between evaluation and the sample write, preceded by the multiply and
// the bit-serial gain divider when the peak is not zero. After reset a clearing pass loads
// the ring RAMs with zero samples, unity gain and zero peaks; no request is accepted during
// it. Configuration writes are taken only while the unit is clearing or idle. The next
// request is accepted once the previous one has reached the response register.
module cycle_peak_lookahead_gain_unit #(
   parameter int DEPTH       = 2048,
   parameter int SAMPLE_BITS = 24
) (
   input wire logic   clock,
   input wire logic   reset,
   cplg_req_if.sink   req_bus,
   cplg_rsp_if.source rsp_bus,
   cplg_csr_if.sink   csr_bus
);
   import cplg_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NLW = $clog2(DEPTH + 1);
   localparam int VW  = (SB > THR_BITS) ? SB : THR_BITS;
   localparam int NW0 = VW + 11;
   localparam int NW  = NW0 + 16;
   localparam int DW  = SB + RATIO_BITS;
   localparam int GPW = GAIN_BITS + SB;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_EVAL, S_MUL, S_DIVS, S_DIVW, S_FILL, S_WR, S_RD, S_OUT
   } state_type;

   state_type             state_ff;
   logic [THR_BITS-1:0]   threshold_ff;
   logic [RATIO_BITS-1:0] ratio_ff;
   logic [LEN_BITS-1:0]   lookahead_ff;
   logic [GUARD_BITS-1:0] guard_ff;
   logic [GUARD_BITS-1:0] count_ff;
   logic                  prev_np_ff;
   logic [SB-1:0]         run_peak_ff;
   logic [SB-1:0]         held_peak_ff;
   logic [AW-1:0]         wpos_ff;
   logic [AW-1:0]         clr_ff;
   logic signed [SB-1:0]  sample_ff;
   logic [AW-1:0]         p_ff;
   logic [AW-1:0]         rd_ff;
   logic [NLW-1:0]        n_ff;
   logic [AW-1:0]         idx_ff;
   logic [16:0]           fill_ff;
   logic [GAIN_BITS-1:0]  gain_ff;
   logic [NW0-1:0]        tr_ff;
   logic [VW-1:0]         over_ff;
   logic [DW-1:0]         den_ff;
   logic                  rsp_valid_ff;
   logic signed [SB-1:0]  rsp_sample_ff;
   logic [GAIN_BITS-1:0]  rsp_gain_ff;
   logic [SB-1:0]         rsp_live_ff;
   logic [SB-1:0]         rsp_peak_ff;

   logic [NLW-1:0]        n_c;
   logic [AW-1:0]         p_c;
   logic [AW-1:0]         rd_c;
   logic [GUARD_BITS-1:0] count_c;
   logic                  cross_c;
   logic [SB-1:0]         mag_c;
   logic [16:0]           fill_c;
   logic [RATIO_BITS-1:0] ratio_c;
   logic [AW-1:0]         idx_next_c;
   logic [NLW-1:0]        n_m1_c;

   logic                  d_wr_en, d_rd_en, gp_wr_en;
   logic [AW-1:0]         d_wr_addr, gp_wr_addr;
   logic [SB-1:0]         d_wr_data, d_rd_data;
   logic [GPW-1:0]        gp_wr_data, gp_rd_data;

   div_ctrl_type          div_ctrl;
   div_stat_type          div_stat;
   logic [NW-1:0]         div_num;
   logic [16:0]           div_gain;

   // Ring length, positions and cycle detection for the request in hand.
   always_comb begin
      if (lookahead_ff == '0) begin
         n_c = NLW'(1);
      end else if (32'(lookahead_ff) > 32'(DEPTH)) begin
         n_c = NLW'(DEPTH);
      end else begin
         n_c = NLW'(lookahead_ff);
      end
      p_c     = (32'(wpos_ff) < 32'(n_c)) ? wpos_ff : '0;
      rd_c    = ((32'(p_c) + 32'd1) >= 32'(n_c)) ? '0 : (p_c + 1'b1);
      count_c = (count_ff < COUNT_MAX) ? (count_ff + 1'b1) : count_ff;
      cross_c = prev_np_ff && !sample_ff[SB-1] && (sample_ff != '0) && (count_c > guard_ff);
      mag_c   = sample_ff[SB-1] ? (~sample_ff + 1'b1) : sample_ff;
      fill_c  = (17'(count_c) > 17'(n_c)) ? 17'(n_c) : 17'(count_c);
      if (ratio_ff < RATIO_MIN) begin
         ratio_c = RATIO_MIN;
      end else if (ratio_ff > RATIO_MAX) begin
         ratio_c = RATIO_MAX;
      end else begin
         ratio_c = ratio_ff;
      end
      n_m1_c     = n_ff - 1'b1;
      idx_next_c = (idx_ff == '0) ? n_m1_c[AW-1:0] : (idx_ff - 1'b1);
   end

   // RAM port selection: clearing pass, write-back, sample write and result read.
   always_comb begin
      d_wr_en    = 1'b0;
      d_wr_addr  = p_ff;
      d_wr_data  = sample_ff;
      gp_wr_en   = 1'b0;
      gp_wr_addr = idx_next_c;
      gp_wr_data = {gain_ff, held_peak_ff};
      d_rd_en    = (state_ff == S_RD);
      unique case (state_ff)
         S_CLEAR: begin
            d_wr_en    = 1'b1;
            d_wr_addr  = clr_ff;
            d_wr_data  = '0;
            gp_wr_en   = 1'b1;
            gp_wr_addr = clr_ff;
            gp_wr_data = {UNITY_GAIN, {SB{1'b0}}};
         end
         S_FILL:  gp_wr_en = 1'b1;
         S_WR:    d_wr_en  = 1'b1;
         default: begin
         end
      endcase
   end

   assign div_ctrl.start = (state_ff == S_DIVS);
   assign div_num = {tr_ff + (NW0'(over_ff) << 4), 16'b0};

   // Sequencer, configuration registers and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         threshold_ff  <= THRESHOLD_RESET;
         ratio_ff      <= RATIO_RESET;
         lookahead_ff  <= LOOKAHEAD_RESET;
         guard_ff      <= GUARD_RESET;
         count_ff      <= '0;
         prev_np_ff    <= 1'b1;
         run_peak_ff   <= '0;
         held_peak_ff  <= '0;
         wpos_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // A taken response empties the register unless a new one is loaded.
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_bus.valid) begin
                  sample_ff <= req_bus.sample;
                  state_ff  <= S_EVAL;
               end
            end
            S_EVAL: begin
               n_ff       <= n_c;
               p_ff       <= p_c;
               rd_ff      <= rd_c;
               idx_ff     <= p_c;
               fill_ff    <= fill_c;
               prev_np_ff <= sample_ff[SB-1] || (sample_ff == '0);
               if (cross_c) begin
                  guard_ff     <= count_c >> 2;
                  held_peak_ff <= run_peak_ff;
                  count_ff     <= '0;
                  run_peak_ff  <= mag_c;
                  gain_ff      <= UNITY_GAIN;
                  state_ff     <= (run_peak_ff == '0) ? S_FILL : S_MUL;
               end else begin
                  count_ff <= count_c;
                  if (mag_c > run_peak_ff) begin
                     run_peak_ff <= mag_c;
                  end
                  state_ff <= S_WR;
               end
            end
            S_MUL: begin
               tr_ff   <= NW0'(threshold_ff) * NW0'(ratio_c);
               over_ff <= (VW'(held_peak_ff) > VW'(threshold_ff)) ?
                          (VW'(held_peak_ff) - VW'(threshold_ff)) : '0;
               den_ff  <= DW'(ratio_c) * DW'(held_peak_ff);
               state_ff <= S_DIVS;
            end
            S_DIVS: state_ff <= S_DIVW;
            S_DIVW: begin
               if (div_stat.done) begin
                  gain_ff  <= div_gain;
                  state_ff <= S_FILL;
               end
            end
            S_FILL: begin
               idx_ff  <= idx_next_c;
               fill_ff <= fill_ff - 1'b1;
               if (fill_ff == 17'd1) begin
                  state_ff <= S_WR;
               end
            end
            S_WR: state_ff <= S_RD;
            S_RD: begin
               wpos_ff  <= rd_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sample_ff <= d_rd_data;
                  rsp_gain_ff   <= gp_rd_data[GPW-1:SB];
                  rsp_peak_ff   <= gp_rd_data[SB-1:0];
                  rsp_live_ff   <= held_peak_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // Configuration writes; a guard write loads the live guard register directly.
         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_bus.index)
               REG_THRESHOLD: threshold_ff <= csr_bus.data[THR_BITS-1:0];
               REG_RATIO:     ratio_ff     <= csr_bus.data[RATIO_BITS-1:0];
               REG_LOOKAHEAD: lookahead_ff <= csr_bus.data[LEN_BITS-1:0];
               REG_GUARD:     guard_ff     <= csr_bus.data[GUARD_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   cplg_ring_ram #(.WIDTH(SB), .DEPTH(DEPTH), .AW(AW)) u_delay_ram (
      .clock   (clock),
      .wr_en   (d_wr_en),
      .wr_addr (d_wr_addr),
      .wr_data (d_wr_data),
      .rd_en   (d_rd_en),
      .rd_addr (rd_ff),
      .rd_data (d_rd_data)
   );

   cplg_ring_ram #(.WIDTH(GPW), .DEPTH(DEPTH), .AW(AW)) u_gain_peak_ram (
      .clock   (clock),
      .wr_en   (gp_wr_en),
      .wr_addr (gp_wr_addr),
      .wr_data (gp_wr_data),
      .rd_en   (d_rd_en),
      .rd_addr (rd_ff),
      .rd_data (gp_rd_data)
   );

   cplg_gain_div #(.NW(NW), .DW(DW)) u_gain_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .num   (div_num),
      .den   (den_ff),
      .stat  (div_stat),
      .gain  (div_gain)
   );

   assign req_bus.ready              = (state_ff == S_IDLE);
   assign csr_bus.ready              = (state_ff == S_IDLE) || (state_ff == S_CLEAR);
   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.delayed_sample     = rsp_sample_ff;
   assign rsp_bus.gain               = rsp_gain_ff;
   assign rsp_bus.live_cycle_peak    = rsp_live_ff;
   assign rsp_bus.delayed_cycle_peak = rsp_peak_ff;

   `CPLG_ASSERT_NEXT(a_accept_eval, req_bus.valid && req_bus.ready, state_ff == S_EVAL, "accepted request did not start evaluation")
   `CPLG_ASSERT_NOW(a_fill_nonzero, state_ff == S_FILL, fill_ff != 17'd0, "write-back with empty count")
   `CPLG_ASSERT_NOW(a_div_done_wait, div_stat.done, state_ff == S_DIVW, "divider finished outside its wait state")
   `CPLG_ASSERT_NOW(a_gain_range, state_ff == S_FILL, gain_ff <= UNITY_GAIN, "write-back gain above unity")
endmodule
`default_nettype wire

>>> sim/cycle_peak_lookahead_gain_unit_tb.sv
// Testbench of the cycle peak lookahead gain unit: directed and random requests.
`timescale 1ns / 1ps
module cycle_peak_lookahead_gain_unit_tb;
   import cplg_pkg::*;

   localparam int DEPTH       = 2048;
   localparam int SAMPLE_BITS = 24;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] delayed_sample;
      logic [GAIN_BITS-1:0]          gain;
      logic [SAMPLE_BITS-1:0]        live_cycle_peak;
      logic [SAMPLE_BITS-1:0]        delayed_cycle_peak;
   } compressor_out_type;

   logic clock;
   logic reset;
   logic calm;
   int   error_count;

   cplg_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   cplg_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();
   cplg_csr_if                              csr_bus ();

   cycle_peak_lookahead_gain_unit #(.DEPTH(DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow of the unit's registers and ring.
   logic [THR_BITS-1:0]    thr_q;
   logic [RATIO_BITS-1:0]  ratio_q;
   logic [LEN_BITS-1:0]    look_q;
   logic [GUARD_BITS-1:0]  guard_init_q;
   logic [SAMPLE_BITS-1:0] sample_ring [DEPTH];
   logic [GAIN_BITS-1:0]   gain_ring   [DEPTH];
   logic [SAMPLE_BITS-1:0] peak_ring   [DEPTH];
   int unsigned            wr_pos;
   logic                   was_nonpos;
   logic [SAMPLE_BITS:0]   cur_peak;
   logic [SAMPLE_BITS:0]   last_peak;
   logic [GUARD_BITS-1:0]  cycle_count;
   logic [GUARD_BITS-1:0]  guard_q;

   compressor_out_type expected_out[$];

   // Clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Overall time limit.
   initial begin
      #20_000_000;
      $display("** cycle_peak_lookahead_gain_unit: FAILED **");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void shadow_reset();
      thr_q        = THRESHOLD_RESET;
      ratio_q      = RATIO_RESET;
      look_q       = LOOKAHEAD_RESET;
      guard_init_q = GUARD_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         sample_ring[i] = '0;
         gain_ring[i]   = UNITY_GAIN;
         peak_ring[i]   = '0;
      end
      wr_pos      = 0;
      was_nonpos  = 1'b1;
      cur_peak    = '0;
      last_peak   = '0;
      cycle_count = '0;
      guard_q     = GUARD_RESET;
   endfunction

   function automatic void shadow_write(input logic [3:0] idx, input logic [23:0] value);
      case (idx)
         REG_THRESHOLD: thr_q   = value[THR_BITS-1:0];
         REG_RATIO:     ratio_q = value[RATIO_BITS-1:0];
         REG_LOOKAHEAD: look_q  = value[LEN_BITS-1:0];
         REG_GUARD: begin
            guard_init_q = value[GUARD_BITS-1:0];
            guard_q      = value[GUARD_BITS-1:0];
         end
         default: ;
      endcase
   endfunction

   function automatic int unsigned ring_length();
      if (look_q == 0) return 1;
      if (look_q > DEPTH) return DEPTH;
      return 32'(look_q);
   endfunction

   // Q16 gain of a finished cycle, exact division rounded down and clamped to unity.
   function automatic logic [GAIN_BITS-1:0] cycle_gain(input logic [SAMPLE_BITS:0] pk);
      logic [63:0] r;
      logic [63:0] over;
      logic [63:0] q;
      if (pk == 0) return UNITY_GAIN;
      r = 64'(ratio_q);
      if (r < 64'(RATIO_MIN)) r = 64'(RATIO_MIN);
      if (r > 64'(RATIO_MAX)) r = 64'(RATIO_MAX);
      over = (pk > thr_q) ? 64'(pk) - 64'(thr_q) : 64'd0;
      q = ((64'(thr_q) * r + 64'd16 * over) * 64'd65536) / (r * 64'(pk));
      if (q > 64'd65536) q = 64'd65536;
      return q[GAIN_BITS-1:0];
   endfunction

   // Advances the shadow by one accepted sample and queues the response it gives.
   function automatic void predict_sample(input logic signed [SAMPLE_BITS-1:0] x);
      int unsigned n;
      int unsigned p;
      int unsigned fill;
      int unsigned idx;
      int unsigned rd;
      logic [GAIN_BITS-1:0] g;
      logic [SAMPLE_BITS:0] mag;
      compressor_out_type o;
      n = ring_length();
      p = (wr_pos < n) ? wr_pos : 0;
      if (cycle_count != COUNT_MAX) cycle_count++;
      if (was_nonpos && x > 0 && cycle_count > guard_q) begin
         fill      = (cycle_count > n) ? n : 32'(cycle_count);
         guard_q   = cycle_count >> 2;
         last_peak = cur_peak;
         g         = cycle_gain(last_peak);
         idx       = p;
         for (int i = 0; i < fill; i++) begin
            idx = (idx == 0) ? n - 1 : idx - 1;
            gain_ring[idx] = g;
            peak_ring[idx] = last_peak[SAMPLE_BITS-1:0];
         end
         cur_peak    = '0;
         cycle_count = '0;
      end
      mag = (x < 0) ? -{x[SAMPLE_BITS-1], x} : {1'b0, x};
      if (mag > cur_peak) cur_peak = mag;
      was_nonpos     = (x <= 0);
      sample_ring[p] = x;
      rd = (p + 1 >= n) ? 0 : p + 1;
      o.delayed_sample     = sample_ring[rd];
      o.gain               = gain_ring[rd];
      o.live_cycle_peak    = last_peak[SAMPLE_BITS-1:0];
      o.delayed_cycle_peak = peak_ring[rd];
      expected_out.push_back(o);
      wr_pos = rd;
   endfunction

   // Watches both channels: accepted requests feed the predictor, responses are checked.
   always @(posedge clock) begin
      compressor_out_type w;
      if (!reset && req_bus.valid && req_bus.ready) predict_sample(req_bus.sample);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_out.size() == 0) begin
            report("unexpected response", 0, 0);
         end else begin
            w = expected_out.pop_front();
            if (rsp_bus.delayed_sample !== w.delayed_sample)
               report("delayed_sample", rsp_bus.delayed_sample, w.delayed_sample);
            if (rsp_bus.gain !== w.gain)
               report("gain", rsp_bus.gain, w.gain);
            if (rsp_bus.live_cycle_peak !== w.live_cycle_peak)
               report("live_cycle_peak", rsp_bus.live_cycle_peak, w.live_cycle_peak);
            if (rsp_bus.delayed_cycle_peak !== w.delayed_cycle_peak)
               report("delayed_cycle_peak", rsp_bus.delayed_cycle_peak, w.delayed_cycle_peak);
         end
      end
   end

   // Response back-pressure.
   always @(negedge clock) begin
      rsp_bus.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 6);
   end

   // Sends one request, idling now and then beforehand.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
      while (!calm && $urandom_range(0, 99) < 6) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid  <= 1'b1;
      req_bus.sample <= x;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drops valid and waits until every response has arrived.
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_out.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [3:0] idx, input logic [23:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      shadow_write(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_config(input logic [23:0] thr, input logic [23:0] ratio,
                             input logic [23:0] len, input logic [23:0] guard);
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_RATIO, ratio);
      write_reg(REG_LOOKAHEAD, len);
      write_reg(REG_GUARD, guard);
   endtask

   // Square-ish wave with random half-cycle lengths, amplitudes and some noise.
   task automatic send_wave(input int count, input int max_half);
      int sent;
      int half;
      int amp;
      logic signed [SAMPLE_BITS-1:0] x;
      bit positive;
      sent = 0;
      positive = 1'b1;
      while (sent < count) begin
         half = $urandom_range(1, max_half);
         amp  = $urandom_range(1, 8388607);
         for (int i = 0; i < half && sent < count; i++) begin
            if ($urandom_range(0, 99) < 15) x = SAMPLE_BITS'($urandom());
            else if (positive) x = SAMPLE_BITS'($urandom_range(1, amp));
            else x = -$signed({1'b0, 23'($urandom_range(0, amp))});
            send_sample(x);
            sent++;
         end
         positive = !positive;
      end
   endtask

   // A few requests under the settings left by reset.
   task automatic test_defaults();
      send_sample(24'sd0);
      send_sample(-24'sd8388608);
      send_sample(24'sd8388607);
      send_sample(-24'sd1);
      send_sample(24'sd1);
      drain();
   endtask

   // Full-scale samples with no delay, zero guard and a zero threshold.
   task automatic test_extremes();
      set_config(24'd0, 24'd16, 24'd1, 24'd0);
      send_sample(-24'sd8388608);
      send_sample(24'sd8388607);
      send_sample(24'sd0);
      send_sample(24'sd5);
      send_sample(-24'sd3);
      send_sample(24'sd8388607);
      drain();
   endtask

   // Ratio below and above its range, threshold with every bit set.
   task automatic test_ratio_clamp();
      set_config(24'hFFFFFF, 24'd0, 24'd5, 24'd1);
      send_sample(-24'sd100); send_sample(24'sd200); send_sample(-24'sd8388608);
      send_sample(24'sd7);
      drain();
      set_config(24'd8388608, 24'h1FF, 24'd5, 24'd1);
      send_sample(-24'sd100); send_sample(24'sd8388607); send_sample(-24'sd50);
      send_sample(24'sd9);
      drain();
   endtask

   // Ring length zero, above depth, the full depth, and a shrink past the write position.
   task automatic test_ring_length();
      set_config(24'd1000, 24'd48, 24'd0, 24'd0);
      send_wave(6, 2);
      drain();
      write_reg(REG_LOOKAHEAD, 24'hFFF);
      send_wave(8, 3);
      drain();
      write_reg(REG_LOOKAHEAD, 24'd2048);
      send_wave(5, 2);
      drain();
      write_reg(REG_LOOKAHEAD, 24'd2);
      send_wave(5, 2);
      drain();
   endtask

   // Writes to indexes that do not exist must change nothing.
   task automatic test_unknown_index();
      write_reg(4'd4, 24'hFFFFFF);
      write_reg(4'hF, 24'hAAAAAA);
      send_wave(4, 2);
      drain();
   endtask

   // Random settings per phase with mostly well-formed waves.
   task automatic test_random();
      logic [23:0] len;
      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 5))
            0:       len = 24'd2048;
            1:       len = 24'd1;
            default: len = 24'($urandom_range(2, 64));
         endcase
         set_config(24'($urandom_range(0, 8388608)), 24'($urandom_range(0, 511)), len,
                    24'($urandom_range(0, 6)));
         calm = (ph == 3);
         send_wave(30, 12);
         drain();
      end
      calm = 1'b0;
   endtask

   initial begin
      error_count    = 0;
      calm           = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      shadow_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_extremes();
      test_ratio_clamp();
      test_ring_length();
      test_unknown_index();
      test_random();

      if (error_count == 0 && expected_out.size() == 0) begin
         $display("** cycle_peak_lookahead_gain_unit: PASSED **");
      end else begin
         $display("** cycle_peak_lookahead_gain_unit: FAILED **");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cplg_pkg.sv
hw/rtl/cplg_channels.sv
hw/rtl/cplg_ring_ram.sv
hw/rtl/cplg_gain_div.sv
hw/rtl/cycle_peak_lookahead_gain_unit.sv
sim/cycle_peak_lookahead_gain_unit_tb.sv
